// ----- hdl/u8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: widths, sequence lengths and the decode result type.
package u8sd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned NEED_W = 2;

	// Sequence lengths in bytes
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

	// Decoded result of one byte, handed from the core to the output register
	typedef struct packed {
		logic              hit;
		logic [CP_W-1:0]   codepoint;
		logic [LEN_W-1:0]  seq_length;
	} dec_res_t;

endpackage

// ----- hdl/u8sd_in_stage.sv -----
// Input register stage of the UTF-8 stream decoder.
module u8sd_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [u8sd_pkg::BYTE_W-1:0]   byte_in,
	input  logic                          last,
	input  logic                          take,
	output logic                          valid_s1,
	output logic [u8sd_pkg::BYTE_W-1:0]   byte_s1,
	output logic                          last_s1
);

	logic load;

	assign load = in_valid && !in_stall;

	// Stage valid: filled on an accepted transaction, emptied when the core takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= byte_in;
			last_s1 <= last;
		end
	end

endmodule

// ----- hdl/u8sd_core.sv -----
// Decode core: sequence state registers and the per-byte decode logic.
module u8sd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [u8sd_pkg::BYTE_W-1:0]   byte_s1,
	input  logic                          last_s1,
	output u8sd_pkg::dec_res_t            res
);

	logic [u8sd_pkg::CP_W-1:0]   partial_q, partial_d;
	logic [u8sd_pkg::NEED_W-1:0] need_q, need_d, need_dec;
	logic [u8sd_pkg::LEN_W-1:0]  size_q, size_d;
	logic [u8sd_pkg::CP_W-1:0]   shifted;
	logic                        is_cont;

	assign is_cont  = (byte_s1[7:6] == 2'b10);
	assign shifted  = {partial_q[u8sd_pkg::CP_W-7:0], byte_s1[5:0]};
	assign need_dec = need_q - 2'd1;

	// Next state and result for the byte in the input stage
	always_comb begin
		partial_d      = partial_q;
		need_d         = need_q;
		size_d         = size_q;
		res.hit        = 1'b0;
		res.codepoint  = shifted;
		res.seq_length = size_q;
		if (byte_s1 == '0) begin
			// terminator drops anything pending
			partial_d = '0;
			need_d    = '0;
			size_d    = u8sd_pkg::LEN_NONE;
		end else if (need_q != '0 && is_cont) begin
			if (need_dec == '0) begin
				res.hit   = 1'b1;
				partial_d = '0;
				need_d    = '0;
				size_d    = u8sd_pkg::LEN_NONE;
			end else begin
				partial_d = shifted;
				need_d    = need_dec;
			end
		end else begin
			// new lead byte; any pending sequence is abandoned
			partial_d = '0;
			need_d    = '0;
			size_d    = u8sd_pkg::LEN_NONE;
			unique casez (byte_s1)
				8'b0???????: begin
					res.hit        = 1'b1;
					res.codepoint  = {13'd0, byte_s1};
					res.seq_length = u8sd_pkg::LEN_ONE;
				end
				8'b110?????: begin
					partial_d = {16'd0, byte_s1[4:0]};
					need_d    = 2'd1;
					size_d    = u8sd_pkg::LEN_TWO;
				end
				8'b1110????: begin
					partial_d = {17'd0, byte_s1[3:0]};
					need_d    = 2'd2;
					size_d    = u8sd_pkg::LEN_THREE;
				end
				8'b11110???: begin
					partial_d = {18'd0, byte_s1[2:0]};
					need_d    = 2'd3;
					size_d    = u8sd_pkg::LEN_FOUR;
				end
				default: begin
					// stray continuation or F8..FF: dropped
				end
			endcase
		end
		// last byte of a string: nothing stays pending
		if (last_s1 && need_d != '0) begin
			partial_d = '0;
			need_d    = '0;
			size_d    = u8sd_pkg::LEN_NONE;
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			need_q    <= '0;
			size_q    <= u8sd_pkg::LEN_NONE;
		end else if (take) begin
			partial_q <= partial_d;
			need_q    <= need_d;
			size_q    <= size_d;
		end
	end

endmodule

// ----- hdl/utf8_stream_decoder_unit.sv -----
// Top level of the UTF-8 stream decoder: input stage, decode core and result register.
// A byte passes the input stage, then the result register, before its code point shows.
// Throughput: one byte per cycle unless a stalled result holds the input back.
// A byte that completes no sequence is taken but produces no transaction.
// Reset (arst_n low, asynchronous): both stages empty, no sequence pending.
module utf8_stream_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [u8sd_pkg::BYTE_W-1:0]   byte_in,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [u8sd_pkg::CP_W-1:0]     codepoint,
	output logic [u8sd_pkg::LEN_W-1:0]    seq_length
);

	logic                         valid_s1;
	logic [u8sd_pkg::BYTE_W-1:0]  byte_s1;
	logic                         last_s1;
	logic                         take;
	logic                         valid_s2;
	logic [u8sd_pkg::CP_W-1:0]    cp_s2;
	logic [u8sd_pkg::LEN_W-1:0]   len_s2;
	u8sd_pkg::dec_res_t           res;

	// Stage 1 moves on when the result register is free or being emptied
	assign take     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !take;

	u8sd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.byte_in  (byte_in),
		.last     (last),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	u8sd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.res     (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= res.hit;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && res.hit) begin
			cp_s2  <= res.codepoint;
			len_s2 <= res.seq_length;
		end
	end

	assign out_valid  = valid_s2;
	assign codepoint  = cp_s2;
	assign seq_length = len_s2;

	// Input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// Every result carries a length of one to four bytes
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (seq_length != u8sd_pkg::LEN_NONE && seq_length <= u8sd_pkg::LEN_FOUR))
		else $error("result with bad sequence length");

	// Single-byte results are plain ASCII
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && seq_length == u8sd_pkg::LEN_ONE) |-> (codepoint < 21'd128))
		else $error("one-byte result above ASCII range");

	// A terminator byte never produces a result
	a_zero_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_s1 == '0) |=> !out_valid)
		else $error("zero byte produced a result");

endmodule

// ----- test/utf8_decode_checker.sv -----
// Checker for the UTF-8 stream decoder: predicts code points from accepted bytes and compares them.
`timescale 1ns / 1ps
module utf8_decode_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [u8sd_pkg::BYTE_W-1:0]    byte_in,
	input  logic                           last,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [u8sd_pkg::CP_W-1:0]      codepoint,
	input  logic [u8sd_pkg::LEN_W-1:0]     seq_length,
	output int unsigned                    mismatch_count,
	output int unsigned                    pending_count,
	output int unsigned                    checked_count
);

	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [u8sd_pkg::CP_W-1:0]  codepoint;
		logic [u8sd_pkg::LEN_W-1:0] seq_length;
	} cp_expect_t;

	// Code points still owed by the block, oldest first
	cp_expect_t expected_cps[$];

	// Predictor state: payload bits so far, continuations still owed, length of the sequence
	logic [u8sd_pkg::CP_W-1:0]   gathered_bits = '0;
	logic [u8sd_pkg::NEED_W-1:0] conts_left    = '0;
	logic [u8sd_pkg::LEN_W-1:0]  pending_len   = u8sd_pkg::LEN_NONE;

	int unsigned n_mismatch = 0;
	int unsigned n_pending  = 0;
	int unsigned n_checked  = 0;

	assign mismatch_count = n_mismatch;
	assign pending_count  = n_pending;
	assign checked_count  = n_checked;

	task automatic clear_pending();
		gathered_bits = '0;
		conts_left    = '0;
		pending_len   = u8sd_pkg::LEN_NONE;
	endtask

	// Advance the predictor by one byte; a finished sequence is queued as expected
	task automatic predict_codepoint(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic is_last);
		cp_expect_t res;
		res = '0;
		if (b == '0) begin
			// terminator: drop anything unfinished
			clear_pending();
		end else begin
			if (conts_left != '0 && b[7:6] == 2'b10) begin
				gathered_bits = {gathered_bits[u8sd_pkg::CP_W-7:0], b[5:0]};
				conts_left    = conts_left - 1'b1;
				if (conts_left == '0) begin
					res.codepoint  = gathered_bits;
					res.seq_length = pending_len;
					expected_cps.push_back(res);
					clear_pending();
				end
			end else begin
				// new lead; a cut-short sequence is lost here
				clear_pending();
				if (!b[7]) begin
					res.codepoint  = {13'd0, b};
					res.seq_length = u8sd_pkg::LEN_ONE;
					expected_cps.push_back(res);
				end else if (b[7:5] == 3'b110) begin
					gathered_bits = {16'd0, b[4:0]};
					conts_left    = 2'd1;
					pending_len   = u8sd_pkg::LEN_TWO;
				end else if (b[7:4] == 4'b1110) begin
					gathered_bits = {17'd0, b[3:0]};
					conts_left    = 2'd2;
					pending_len   = u8sd_pkg::LEN_THREE;
				end else if (b[7:3] == 5'b11110) begin
					gathered_bits = {18'd0, b[2:0]};
					conts_left    = 2'd3;
					pending_len   = u8sd_pkg::LEN_FOUR;
				end
				// stray continuations and F8..FF fall through and are dropped
			end
			if (is_last && conts_left != '0)
				clear_pending();
		end
	endtask

	// Compare results first: a byte taken at this edge must still pass both registered stages
	always @(posedge clk) begin : watch_channels
		cp_expect_t want;
		if (!arst_n) begin
			clear_pending();
			expected_cps.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_cps.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS)
						$display("%0t: unexpected transaction cp=%h len=%0d, nothing expected",
							$realtime, codepoint, seq_length);
				end else begin
					want = expected_cps.pop_front();
					n_checked++;
					if (codepoint !== want.codepoint || seq_length !== want.seq_length) begin
						n_mismatch++;
						if (n_mismatch <= MAX_REPORTS)
							$display("%0t: mismatch expected cp=%h len=%0d, got cp=%h len=%0d",
								$realtime, want.codepoint, want.seq_length,
								codepoint, seq_length);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_codepoint(byte_in, last);
		end
		n_pending = expected_cps.size();
	end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the UTF-8 stream decoder: byte stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned RAND_BYTES   = 1500;
	localparam int unsigned IDLE_PCT     = 36;
	localparam int unsigned CALM_FROM    = 700;
	localparam int unsigned CALM_TO      = 1000;
	localparam int unsigned STUCK_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [u8sd_pkg::BYTE_W-1:0] value;
		logic                        is_last;
	} text_byte_t;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        in_valid   = 1'b0;
	logic                        in_stall;
	logic [u8sd_pkg::BYTE_W-1:0] byte_in    = '0;
	logic                        last       = 1'b0;
	logic                        out_valid;
	logic                        out_stall  = 1'b0;
	logic [u8sd_pkg::CP_W-1:0]   codepoint;
	logic [u8sd_pkg::LEN_W-1:0]  seq_length;

	// High while neither side idles
	logic calm = 1'b0;

	int unsigned mismatch_count;
	int unsigned pending_count;
	int unsigned checked_count;

	text_byte_t  text_q[$];
	int unsigned n_sent       = 0;
	int unsigned n_directed   = 0;
	int unsigned stuck_cycles = 0;

	utf8_stream_decoder_unit i_dut (.*);

	utf8_decode_checker i_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic add_byte(input logic [u8sd_pkg::BYTE_W-1:0] v, input logic l);
		text_q.push_back({v, l});
	endtask

	// n-byte sequence with random payload bits, cut after keep bytes; last flag on the final one if end_last is set
	task automatic add_sequence(input int unsigned n, input int unsigned keep, input logic end_last);
		logic [u8sd_pkg::BYTE_W-1:0] lead;
		case (n)
			1: lead = 8'($urandom_range(1, 127));
			2: lead = 8'hC0 | 8'($urandom_range(0, 31));
			3: lead = 8'hE0 | 8'($urandom_range(0, 15));
			default: lead = 8'hF0 | 8'($urandom_range(0, 7));
		endcase
		add_byte(lead, end_last && keep == 1);
		for (int i = 1; i < keep; i++)
			add_byte(8'h80 | 8'($urandom_range(0, 63)), end_last && i == keep - 1);
	endtask

	// Receiver side: random stalls, none during the calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		int unsigned keep;
		int unsigned pick;
		logic        calm_now;

		// Directed: ASCII extremes and the terminator
		add_byte(8'h01, 1'b0); add_byte(8'h7F, 1'b0); add_byte(8'h00, 1'b0);
		// overlong NUL and a surrogate are passed through
		add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
		// F7 lead with full payload gives the top value
		add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		// stray continuation and bad leads
		add_byte(8'h80, 1'b0); add_byte(8'hF8, 1'b0); add_byte(8'hFF, 1'b0);
		// cut short by ASCII, which still decodes
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'h41, 1'b0);
		// zero inside a sequence, tail becomes stray
		add_byte(8'hC3, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hA9, 1'b0);
		// last flag mid-sequence drops it; last on the final byte still completes
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1); add_byte(8'hAC, 1'b0);
		add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b1);
		n_directed = text_q.size();

		// Random: mostly well-formed sequences, the rest broken or noise
		while (text_q.size() < n_directed + RAND_BYTES) begin
			len  = $urandom_range(1, 4);
			keep = $urandom_range(1, len);
			pick = $urandom_range(99);
			if (pick < 78) begin
				add_sequence(len, len, $urandom_range(7) == 0);
			end else if (pick < 84) begin
				add_sequence(len, keep, 1'b0);
			end else if (pick < 88) begin
				add_sequence(len, keep, 1'b1);
				repeat (len - keep) add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
			end else if (pick < 92) begin
				add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'($urandom_range(1)));
			end else if (pick < 95) begin
				add_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'($urandom_range(1)));
			end else if (pick < 97) begin
				add_byte(8'h00, 1'($urandom_range(1)));
			end else begin
				add_byte(8'($urandom), 1'($urandom_range(1)));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Sender: a stalled transaction holds its payload until taken
		while (n_sent < text_q.size()) begin
			@(posedge clk);
			if (in_valid && !in_stall)
				n_sent++;
			calm_now = (n_sent >= CALM_FROM && n_sent < CALM_TO);
			calm <= calm_now;
			if (!in_valid || !in_stall) begin
				if (n_sent < text_q.size() && (calm_now || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					byte_in  <= text_q[n_sent].value;
					last     <= text_q[n_sent].is_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end

		// Drain the owed code points, then keep watching for extras
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d bytes sent (%0d directed), %0d code points checked",
			n_sent, n_directed, checked_count);
		$display("Summary: 1-4 byte sequences with cut-short, stray, bad-lead, zero and last noise");
		if (mismatch_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
